@@ rtl/sdspi_pkg.sv @@
`default_nettype none
package sdspi_pkg;

	localparam int unsigned BLOCK_BYTES      = 512;
	localparam int unsigned IDLE_CLOCK_BYTES = 10;
	localparam int unsigned RESPONSE_TRIES   = 8;

	localparam logic [2:0] KIND_INIT  = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_WRITE = 3'd2;
	localparam logic [2:0] KIND_XFER  = 3'd3;
	localparam logic [2:0] KIND_TICK  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_INIT = 2'd1;
	localparam logic [1:0] ST_IO   = 2'd2;

	localparam logic [0:0] REG_ACMD41 = 1'b0;
	localparam logic [0:0] REG_POLL   = 1'b1;

	localparam logic [5:0] CMD0  = 6'd0;
	localparam logic [5:0] CMD8  = 6'd8;
	localparam logic [5:0] CMD16 = 6'd16;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] CMD41 = 6'd41;
	localparam logic [5:0] CMD55 = 6'd55;
	localparam logic [5:0] CMD58 = 6'd58;

	typedef enum logic [17:0] {
		PH_IDLE     = 18'h00001,
		PH_CLOCKS   = 18'h00002,
		PH_WAITRDY  = 18'h00004,
		PH_CMDBYTES = 18'h00008,
		PH_RESP     = 18'h00010,
		PH_R7       = 18'h00020,
		PH_OCR      = 18'h00040,
		PH_TICK     = 18'h00080,
		PH_TRAIL    = 18'h00100,
		PH_TOKEN    = 18'h00200,
		PH_RDATA    = 18'h00400,
		PH_RCRC     = 18'h00800,
		PH_WGAP     = 18'h01000,
		PH_WTOKEN   = 18'h02000,
		PH_WDATA    = 18'h04000,
		PH_WCRC     = 18'h08000,
		PH_WRESP    = 18'h10000,
		PH_WBUSY    = 18'h20000
	} phase_t;

	typedef struct packed {
		logic [1:0] card_type;
		logic [1:0] status;
		logic       done_res;
		logic       wr_taken;
		logic       rd_last;
		logic [7:0] rd_byte;
		logic       rd_valid;
		logic       wait_tick;
		logic       fast_clock;
		logic       chip_select_active;
		logic [7:0] tx_byte;
		logic       send_valid;
	} result_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] block_address;
		logic [7:0]  rx_byte;
		logic [7:0]  wr_byte;
	} item_t;

endpackage
`default_nettype wire

@@ rtl/sdspi_engine.sv @@
`default_nettype none
// Protocol sequencer: one item in, one result out, combinational next state.
module sdspi_engine #(
	parameter int unsigned IDLE_CLOCK_BYTES = sdspi_pkg::IDLE_CLOCK_BYTES,
	parameter int unsigned RESPONSE_TRIES   = sdspi_pkg::RESPONSE_TRIES
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  sdspi_pkg::item_t       item,
	input  wire  [7:0]             acmd41_attempts,
	input  wire  [15:0]            busy_poll_limit,
	output sdspi_pkg::result_t     res
);
	localparam int unsigned BB = sdspi_pkg::BLOCK_BYTES;

	sdspi_pkg::phase_t phase_q, phase_d;
	logic [9:0]  byte_count_q, byte_count_d;
	logic [15:0] poll_count_q, poll_count_d;
	logic [7:0]  attempt_q, attempt_d;
	logic [1:0]  dtype_q, dtype_d;
	logic [47:0] frame_q, frame_d;
	logic [15:0] reply_q, reply_d;
	logic        v2_q, v2_d, fast_q, fast_d;

	logic [9:0]  bc_inc;
	logic [15:0] pc_inc;
	logic [7:0]  att_inc;
	logic [5:0]  fcmd;
	logic [31:0] caddr;
	logic [7:0]  rx;

	always_comb begin
		bc_inc  = byte_count_q + 10'd1;
		pc_inc  = poll_count_q + 16'd1;
		att_inc = attempt_q + 8'd1;
		fcmd    = frame_q[45:40];
		rx      = item.rx_byte;
		caddr   = (dtype_q == 2'd3) ? item.block_address
			: {item.block_address[22:0], 9'd0};
	end

	// state moves and result
	always_comb begin
		logic [5:0]  c;
		logic [31:0] a;
		logic [7:0]  k;
		logic        sc;
		phase_d = phase_q; byte_count_d = byte_count_q; poll_count_d = poll_count_q;
		attempt_d = attempt_q; dtype_d = dtype_q; frame_d = frame_q;
		reply_d = reply_q; v2_d = v2_q; fast_d = fast_q;
		res = '0;
		sc = 1'b0; c = '0; a = '0; k = '0;
		unique case (item.kind)
			sdspi_pkg::KIND_INIT: begin
				if (phase_q == sdspi_pkg::PH_IDLE) begin
					fast_d = 1'b0; phase_d = sdspi_pkg::PH_CLOCKS; byte_count_d = '0;
					res.send_valid = 1'b1; res.tx_byte = 8'hFF;
				end
			end
			sdspi_pkg::KIND_READ, sdspi_pkg::KIND_WRITE: begin
				if (phase_q == sdspi_pkg::PH_IDLE) begin
					sc = 1'b1;
					c = (item.kind == sdspi_pkg::KIND_READ) ? sdspi_pkg::CMD17
						: sdspi_pkg::CMD24;
					a = caddr; k = 8'hFF;
				end
			end
			sdspi_pkg::KIND_TICK: begin
				if (phase_q == sdspi_pkg::PH_TICK) begin
					sc = 1'b1; c = sdspi_pkg::CMD55; k = 8'h65;
				end
			end
			sdspi_pkg::KIND_XFER: begin
				unique case (phase_q)
					sdspi_pkg::PH_CLOCKS: begin
						byte_count_d = bc_inc;
						if (bc_inc < 10'(IDLE_CLOCK_BYTES)) begin
							res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						end else begin
							sc = 1'b1; c = sdspi_pkg::CMD0; k = 8'h95;
						end
					end
					sdspi_pkg::PH_WAITRDY: begin
						poll_count_d = pc_inc;
						res.send_valid = 1'b1; res.chip_select_active = 1'b1;
						if (rx == 8'hFF || pc_inc == busy_poll_limit) begin
							phase_d = sdspi_pkg::PH_CMDBYTES; byte_count_d = '0;
							res.tx_byte = frame_q[47:40];
						end else res.tx_byte = 8'hFF;
					end
					sdspi_pkg::PH_CMDBYTES: begin
						byte_count_d = bc_inc;
						res.send_valid = 1'b1; res.chip_select_active = 1'b1;
						if (bc_inc < 10'd6) begin
							case (bc_inc[2:0])
								3'd1: res.tx_byte = frame_q[39:32];
								3'd2: res.tx_byte = frame_q[31:24];
								3'd3: res.tx_byte = frame_q[23:16];
								3'd4: res.tx_byte = frame_q[15:8];
								default: res.tx_byte = frame_q[7:0];
							endcase
						end else begin
							phase_d = sdspi_pkg::PH_RESP; poll_count_d = '0;
							res.tx_byte = 8'hFF;
						end
					end
					sdspi_pkg::PH_RESP: begin
						poll_count_d = pc_inc;
						res.send_valid = 1'b1; res.chip_select_active = 1'b1;
						res.tx_byte = 8'hFF;
						if (!rx[7] || pc_inc >= 16'(RESPONSE_TRIES)) begin
							reply_d = {reply_q[15:8], rx};
							res.chip_select_active = 1'b0;
							phase_d = sdspi_pkg::PH_TRAIL;
							case (fcmd)
								sdspi_pkg::CMD8: if (rx == 8'h01) begin
									phase_d = sdspi_pkg::PH_R7; byte_count_d = '0;
									res.chip_select_active = 1'b1;
								end
								sdspi_pkg::CMD58: begin
									phase_d = sdspi_pkg::PH_OCR; byte_count_d = '0;
									res.chip_select_active = 1'b1;
								end
								sdspi_pkg::CMD17: if (rx != 8'h00)
									reply_d = {6'd0, sdspi_pkg::ST_IO, 8'd0};
								else begin
									phase_d = sdspi_pkg::PH_TOKEN; poll_count_d = '0;
									res.chip_select_active = 1'b1;
								end
								sdspi_pkg::CMD24: if (rx != 8'h00)
									reply_d = {6'd0, sdspi_pkg::ST_IO, 8'd0};
								else begin
									phase_d = sdspi_pkg::PH_WGAP;
									res.chip_select_active = 1'b1;
								end
								default: ;
							endcase
						end
					end
					sdspi_pkg::PH_R7: begin
						res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						if (byte_count_q >= 10'd3) begin
							reply_d = {7'd0, (reply_q[15:8] == 8'h01 && rx == 8'hAA),
								reply_q[7:0]};
							phase_d = sdspi_pkg::PH_TRAIL;
						end else begin
							if (byte_count_q == 10'd2) reply_d = {rx, reply_q[7:0]};
							byte_count_d = bc_inc; res.chip_select_active = 1'b1;
						end
					end
					sdspi_pkg::PH_OCR: begin
						res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						if (byte_count_q == 10'd0) reply_d = {rx, reply_q[7:0]};
						if (byte_count_q >= 10'd3) phase_d = sdspi_pkg::PH_TRAIL;
						else begin
							byte_count_d = bc_inc; res.chip_select_active = 1'b1;
						end
					end
					sdspi_pkg::PH_TRAIL: begin
						res.done_res = 1'b1; phase_d = sdspi_pkg::PH_IDLE;
						case (fcmd)
							sdspi_pkg::CMD0: if (reply_q[7:0] == 8'h01) begin
								res.done_res = 1'b0; sc = 1'b1; c = sdspi_pkg::CMD8;
								a = 32'h000001AA; k = 8'h87;
							end else res.status = sdspi_pkg::ST_INIT;
							sdspi_pkg::CMD8: if (reply_q[7:0] == 8'h01
								&& reply_q[15:8] != 8'h01) res.status = sdspi_pkg::ST_INIT;
							else begin
								res.done_res = 1'b0; v2_d = (reply_q[7:0] == 8'h01);
								attempt_d = '0; phase_d = sdspi_pkg::PH_TICK;
							end
							sdspi_pkg::CMD55: begin
								res.done_res = 1'b0; sc = 1'b1; c = sdspi_pkg::CMD41;
								a = v2_q ? 32'h40000000 : 32'd0; k = 8'h77;
							end
							sdspi_pkg::CMD41: begin
								res.done_res = 1'b0;
								if (reply_q[7:0] == 8'h00) begin
									sc = 1'b1; k = 8'hFF;
									if (v2_q) c = sdspi_pkg::CMD58;
									else begin
										dtype_d = 2'd1; c = sdspi_pkg::CMD16; a = 32'(BB);
									end
								end else begin
									attempt_d = att_inc;
									if (att_inc == acmd41_attempts) begin
										res.done_res = 1'b1; res.status = sdspi_pkg::ST_INIT;
									end else phase_d = sdspi_pkg::PH_TICK;
								end
							end
							sdspi_pkg::CMD58: if (reply_q[7:0] != 8'h00)
								res.status = sdspi_pkg::ST_INIT;
							else begin
								res.done_res = 1'b0;
								dtype_d = reply_q[14] ? 2'd3 : 2'd2;
								sc = 1'b1; c = sdspi_pkg::CMD16; a = 32'(BB); k = 8'hFF;
							end
							sdspi_pkg::CMD16: if (reply_q[7:0] != 8'h00 && dtype_q != 2'd3)
								res.status = sdspi_pkg::ST_INIT;
							else fast_d = 1'b1;
							default: res.status = reply_q[9:8];
						endcase
					end
					sdspi_pkg::PH_TOKEN: begin
						poll_count_d = pc_inc; res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						res.chip_select_active = 1'b1;
						if (rx == 8'hFE) begin
							phase_d = sdspi_pkg::PH_RDATA; byte_count_d = '0;
						end else if (pc_inc == busy_poll_limit) begin
							reply_d = {6'd0, sdspi_pkg::ST_IO, 8'd0};
							phase_d = sdspi_pkg::PH_TRAIL; res.chip_select_active = 1'b0;
						end
					end
					sdspi_pkg::PH_RDATA: begin
						res.rd_valid = 1'b1; res.rd_byte = rx;
						res.rd_last = (byte_count_q == 10'(BB - 1));
						byte_count_d = bc_inc;
						if (res.rd_last) begin
							phase_d = sdspi_pkg::PH_RCRC; byte_count_d = '0;
						end
						res.send_valid = 1'b1; res.tx_byte = 8'hFF; res.chip_select_active = 1'b1;
					end
					sdspi_pkg::PH_RCRC: begin
						byte_count_d = bc_inc; res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						if (bc_inc >= 10'd2) begin
							reply_d = {6'd0, sdspi_pkg::ST_OK, 8'd0};
							phase_d = sdspi_pkg::PH_TRAIL;
						end else res.chip_select_active = 1'b1;
					end
					sdspi_pkg::PH_WGAP: begin
						phase_d = sdspi_pkg::PH_WTOKEN; res.send_valid = 1'b1;
						res.tx_byte = 8'hFE; res.chip_select_active = 1'b1;
					end
					sdspi_pkg::PH_WTOKEN: begin
						phase_d = sdspi_pkg::PH_WDATA; byte_count_d = '0; res.wr_taken = 1'b1;
						res.send_valid = 1'b1; res.tx_byte = item.wr_byte;
						res.chip_select_active = 1'b1;
					end
					sdspi_pkg::PH_WDATA: begin
						byte_count_d = bc_inc; res.send_valid = 1'b1;
						res.chip_select_active = 1'b1;
						if (bc_inc < 10'(BB)) begin
							res.wr_taken = 1'b1; res.tx_byte = item.wr_byte;
						end else begin
							phase_d = sdspi_pkg::PH_WCRC; byte_count_d = '0;
							res.tx_byte = 8'hFF;
						end
					end
					sdspi_pkg::PH_WCRC: begin
						byte_count_d = bc_inc;
						if (bc_inc >= 10'd2) phase_d = sdspi_pkg::PH_WRESP;
						res.send_valid = 1'b1; res.tx_byte = 8'hFF; res.chip_select_active = 1'b1;
					end
					sdspi_pkg::PH_WRESP: begin
						res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						if (rx[4:0] != 5'h05) begin
							reply_d = {6'd0, sdspi_pkg::ST_IO, 8'd0};
							phase_d = sdspi_pkg::PH_TRAIL;
						end else begin
							phase_d = sdspi_pkg::PH_WBUSY; poll_count_d = '0;
							res.chip_select_active = 1'b1;
						end
					end
					sdspi_pkg::PH_WBUSY: begin
						poll_count_d = pc_inc; res.send_valid = 1'b1; res.tx_byte = 8'hFF;
						if (rx != 8'h00) begin
							reply_d = {6'd0, sdspi_pkg::ST_OK, 8'd0};
							phase_d = sdspi_pkg::PH_TRAIL;
						end else if (pc_inc == busy_poll_limit) begin
							reply_d = {6'd0, sdspi_pkg::ST_IO, 8'd0};
							phase_d = sdspi_pkg::PH_TRAIL;
						end else res.chip_select_active = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (sc) begin
			frame_d = {2'b01, c, a, k[7:1], 1'b1};
			phase_d = sdspi_pkg::PH_WAITRDY; poll_count_d = '0;
			res.send_valid = 1'b1; res.tx_byte = 8'hFF; res.chip_select_active = 1'b1;
		end
		res.fast_clock = fast_d;
		res.wait_tick  = (phase_d == sdspi_pkg::PH_TICK);
		res.card_type  = dtype_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE; byte_count_q <= '0; poll_count_q <= '0;
			attempt_q <= '0; dtype_q <= '0; frame_q <= '0; reply_q <= '0;
			v2_q <= 1'b0; fast_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d; byte_count_q <= byte_count_d; poll_count_q <= poll_count_d;
			attempt_q <= attempt_d; dtype_q <= dtype_d; frame_q <= frame_d;
			reply_q <= reply_d; v2_q <= v2_d; fast_q <= fast_d;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(phase_q))
		else $error("phase not one-hot");
	a_cs: assert property (@(posedge clk) disable iff (!arst_n)
		res.chip_select_active |-> res.send_valid) else $error("cs without send");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		res.rd_last |-> res.rd_valid) else $error("rd_last without rd_valid");
	a_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == sdspi_pkg::PH_RDATA) |=> phase_q != sdspi_pkg::PH_TICK)
		else $error("read jumped to tick wait");
endmodule
`default_nettype wire

@@ rtl/sd_spi_card_controller_top.sv @@
`default_nettype none
// SPI-mode SD card host engine.
// s_axis: one word per event: an init/read/write start, a finished SPI byte
//   exchange (with the received byte and the next write byte), or a 10 ms tick.
// m_axis: one result word per input word: the next byte to shift (send_valid,
//   tx_byte, chip select), clock select, tick wait, read data, write-byte
//   consumption, done with status, and the detected card type.
// Config: cfg_we/cfg_index/cfg_data; index 0 acmd41_attempts, 1 busy_poll_limit.
//   Write only while idle.
// A result word appears in the cycle after its input word is taken.
// Throughput: one word per cycle unless m_axis stalls; the engine's next-state logic
//   sits between the input handshake and a single output register.
// Stall: when m_axis_tready is low with a word held, the output register holds and
//   s_axis_tready follows it, so the input is held off; no word is dropped.
// Reset: engine idle, slow clock, unknown card, registers at 200 / 65535.
module sd_spi_card_controller_top #(
	parameter int unsigned IDLE_CLOCK_BYTES = sdspi_pkg::IDLE_CLOCK_BYTES,
	parameter int unsigned RESPONSE_TRIES   = sdspi_pkg::RESPONSE_TRIES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] kind, [34:3] block_address, [42:35] rx_byte, [50:43] wr_byte, pad
	input  wire  [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [0] send_valid,[8:1] tx_byte,[9] chip_select_active,[10] fast_clock,
	// [11] wait_tick,[12] rd_valid,[20:13] rd_byte,[21] wr_taken,[22] done_res,
	// [24:23] status,[26:25] card_type, pad
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	logic [7:0]  acmd41_q;
	logic [15:0] poll_limit_q;
	sdspi_pkg::item_t   item;
	sdspi_pkg::result_t res;
	logic step;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign step = s_axis_tvalid && s_axis_tready;
	assign item.kind = s_axis_tdata[2:0];
	assign item.block_address = s_axis_tdata[34:3];
	assign item.rx_byte = s_axis_tdata[42:35];
	assign item.wr_byte = s_axis_tdata[50:43];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acmd41_q <= 8'd200; poll_limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdspi_pkg::REG_ACMD41: acmd41_q <= cfg_data[7:0];
				sdspi_pkg::REG_POLL:   poll_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sdspi_engine #(
		.IDLE_CLOCK_BYTES(IDLE_CLOCK_BYTES),
		.RESPONSE_TRIES(RESPONSE_TRIES)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .step(step), .item(item),
		.acmd41_attempts(acmd41_q), .busy_poll_limit(poll_limit_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (s_axis_tready) m_axis_tvalid <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_axis_tdata <= {5'd0, res.card_type, res.status, res.done_res, res.wr_taken,
				res.rd_byte, res.rd_valid, res.wait_tick, res.fast_clock,
				res.chip_select_active, res.tx_byte, res.send_valid};
			m_axis_tlast <= res.rd_last;
		end
	end
endmodule
`default_nettype wire

@@ tb/sd_spi_card_controller_top_tb.sv @@
`default_nettype none
module sd_spi_card_controller_top_tb;

	localparam int unsigned CYCLE_LIMIT = 3000000;

	// engine phases, numbered for the local predictor only
	typedef enum logic [4:0] {
		E_IDLE, E_CLOCKS, E_WAITRDY, E_CMDBYTES, E_RESP, E_R7, E_OCR, E_TICK,
		E_TRAIL, E_TOKEN, E_RDATA, E_RCRC, E_WGAP, E_WTOKEN, E_WDATA, E_WCRC,
		E_WRESP, E_WBUSY
	} eng_phase_t;

	typedef struct packed {
		logic       send;
		logic [7:0] tx;
		logic       cs;
		logic       fast;
		logic       wtick;
		logic       rdv;
		logic [7:0] rdb;
		logic       rdl;
		logic       wrt;
		logic       done;
		logic [1:0] st;
		logic [1:0] ctype;
	} card_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	sd_spi_card_controller_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	eng_phase_t  ph;
	logic [15:0] nbytes, npoll;
	logic [7:0]  natt, att_lim;
	logic [15:0] poll_lim;
	logic [1:0]  ctype;
	logic [47:0] frame;
	logic [15:0] reply;
	logic        v2, fast;
	card_word_t  w;

	card_word_t  expected_words[$];
	int          errors = 0;
	longint      cycles = 0;
	bit          stall_rx = 1'b0;  // receiver long stall mode

	// ---- predictor ----
	function automatic void emit(logic [7:0] b, logic cs);
		w.send = 1'b1; w.tx = b; w.cs = cs;
	endfunction

	function automatic void finish_op(logic [1:0] s);
		ph = E_IDLE; w.done = 1'b1; w.st = s;
	endfunction

	function automatic void start_cmd(logic [5:0] c, logic [31:0] arg, logic [7:0] crc);
		frame = {2'b01, c, arg, crc | 8'h01};
		ph = E_WAITRDY; npoll = '0; emit(8'hFF, 1'b1);
	endfunction

	function automatic void trailer();
		ph = E_TRAIL; emit(8'hFF, 1'b0);
	endfunction

	function automatic logic [5:0] fcmd();
		return frame[45:40];
	endfunction

	function automatic void on_response(logic [7:0] r);
		reply[7:0] = r;
		case (fcmd())
			sdspi_pkg::CMD8: if (r == 8'h01) begin
				ph = E_R7; nbytes = '0; emit(8'hFF, 1'b1);
			end else trailer();
			sdspi_pkg::CMD58: begin
				ph = E_OCR; nbytes = '0; emit(8'hFF, 1'b1);
			end
			sdspi_pkg::CMD17: if (r != 8'h00) begin
				reply = {6'd0, sdspi_pkg::ST_IO, 8'd0}; trailer();
			end else begin
				ph = E_TOKEN; npoll = '0; emit(8'hFF, 1'b1);
			end
			sdspi_pkg::CMD24: if (r != 8'h00) begin
				reply = {6'd0, sdspi_pkg::ST_IO, 8'd0}; trailer();
			end else begin
				ph = E_WGAP; emit(8'hFF, 1'b1);
			end
			default: trailer();
		endcase
	endfunction

	function automatic void on_trailer();
		logic [7:0] r1, hi;
		r1 = reply[7:0];
		hi = reply[15:8];
		case (fcmd())
			sdspi_pkg::CMD0: if (r1 == 8'h01) start_cmd(sdspi_pkg::CMD8, 32'h1AA, 8'h87);
				else finish_op(sdspi_pkg::ST_INIT);
			sdspi_pkg::CMD8: if (r1 == 8'h01) begin
				if (hi == 8'h01) begin
					v2 = 1'b1; natt = '0; ph = E_TICK;
				end else finish_op(sdspi_pkg::ST_INIT);
			end else begin
				v2 = 1'b0; natt = '0; ph = E_TICK;
			end
			sdspi_pkg::CMD55: start_cmd(sdspi_pkg::CMD41, v2 ? 32'h4000_0000 : 32'h0, 8'h77);
			sdspi_pkg::CMD41: if (r1 == 8'h00) begin
				if (v2) start_cmd(sdspi_pkg::CMD58, '0, 8'hFF);
				else begin
					ctype = 2'd1;
					start_cmd(sdspi_pkg::CMD16, 32'(sdspi_pkg::BLOCK_BYTES), 8'hFF);
				end
			end else begin
				natt = natt + 8'd1;
				if (natt == att_lim) finish_op(sdspi_pkg::ST_INIT);
				else ph = E_TICK;
			end
			sdspi_pkg::CMD58: if (r1 != 8'h00) finish_op(sdspi_pkg::ST_INIT);
				else begin
					ctype = hi[6] ? 2'd3 : 2'd2;
					start_cmd(sdspi_pkg::CMD16, 32'(sdspi_pkg::BLOCK_BYTES), 8'hFF);
				end
			sdspi_pkg::CMD16: if (r1 != 8'h00 && ctype != 2'd3) finish_op(sdspi_pkg::ST_INIT);
				else begin
					fast = 1'b1; finish_op(sdspi_pkg::ST_OK);
				end
			default: finish_op(hi[1:0]);
		endcase
	endfunction

	function automatic void on_exchange(logic [7:0] rx, logic [7:0] wr);
		case (ph)
			E_CLOCKS: begin
				nbytes++;
				if (nbytes < sdspi_pkg::IDLE_CLOCK_BYTES) emit(8'hFF, 1'b0);
				else start_cmd(sdspi_pkg::CMD0, '0, 8'h95);
			end
			E_WAITRDY: begin
				npoll++;
				if (rx == 8'hFF || npoll == poll_lim) begin
					ph = E_CMDBYTES; nbytes = '0; emit(frame[47:40], 1'b1);
				end else emit(8'hFF, 1'b1);
			end
			E_CMDBYTES: begin
				nbytes++;
				if (nbytes < 16'd6) emit(8'(frame >> (16'd40 - 16'd8 * nbytes)), 1'b1);
				else begin
					ph = E_RESP; npoll = '0; emit(8'hFF, 1'b1);
				end
			end
			E_RESP: begin
				npoll++;
				if (!rx[7] || npoll >= sdspi_pkg::RESPONSE_TRIES) on_response(rx);
				else emit(8'hFF, 1'b1);
			end
			E_R7: begin
				if (nbytes == 16'd2) reply[15:8] = rx;
				if (nbytes >= 16'd3) begin
					reply[15:8] = (reply[15:8] == 8'h01 && rx == 8'hAA) ? 8'h01 : 8'h00;
					trailer();
				end else begin
					nbytes++; emit(8'hFF, 1'b1);
				end
			end
			E_OCR: begin
				if (nbytes == 16'd0) reply[15:8] = rx;
				if (nbytes >= 16'd3) trailer();
				else begin
					nbytes++; emit(8'hFF, 1'b1);
				end
			end
			E_TRAIL: on_trailer();
			E_TOKEN: begin
				npoll++;
				if (rx == 8'hFE) begin
					ph = E_RDATA; nbytes = '0; emit(8'hFF, 1'b1);
				end else if (npoll == poll_lim) begin
					reply = {6'd0, sdspi_pkg::ST_IO, 8'd0}; trailer();
				end else emit(8'hFF, 1'b1);
			end
			E_RDATA: begin
				w.rdv = 1'b1; w.rdb = rx;
				w.rdl = (nbytes == 16'(sdspi_pkg::BLOCK_BYTES - 1));
				nbytes++;
				if (nbytes >= sdspi_pkg::BLOCK_BYTES) begin
					ph = E_RCRC; nbytes = '0;
				end
				emit(8'hFF, 1'b1);
			end
			E_RCRC: begin
				nbytes++;
				if (nbytes >= 16'd2) begin
					reply = {6'd0, sdspi_pkg::ST_OK, 8'd0}; trailer();
				end else emit(8'hFF, 1'b1);
			end
			E_WGAP: begin
				ph = E_WTOKEN; emit(8'hFE, 1'b1);
			end
			E_WTOKEN: begin
				ph = E_WDATA; nbytes = '0; w.wrt = 1'b1; emit(wr, 1'b1);
			end
			E_WDATA: begin
				nbytes++;
				if (nbytes < sdspi_pkg::BLOCK_BYTES) begin
					w.wrt = 1'b1; emit(wr, 1'b1);
				end else begin
					ph = E_WCRC; nbytes = '0; emit(8'hFF, 1'b1);
				end
			end
			E_WCRC: begin
				nbytes++;
				if (nbytes >= 16'd2) ph = E_WRESP;
				emit(8'hFF, 1'b1);
			end
			E_WRESP: if (rx[4:0] != 5'h05) begin
				reply = {6'd0, sdspi_pkg::ST_IO, 8'd0}; trailer();
			end else begin
				ph = E_WBUSY; npoll = '0; emit(8'hFF, 1'b1);
			end
			E_WBUSY: begin
				npoll++;
				if (rx != 8'h00) begin
					reply = {6'd0, sdspi_pkg::ST_OK, 8'd0}; trailer();
				end else if (npoll == poll_lim) begin
					reply = {6'd0, sdspi_pkg::ST_IO, 8'd0}; trailer();
				end else emit(8'hFF, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic card_word_t predict_card_word(logic [2:0] k, logic [31:0] lba,
			logic [7:0] rx, logic [7:0] wr);
		w = '0;
		case (k)
			sdspi_pkg::KIND_INIT: if (ph == E_IDLE) begin
				fast = 1'b0; ph = E_CLOCKS; nbytes = '0; emit(8'hFF, 1'b0);
			end
			sdspi_pkg::KIND_READ, sdspi_pkg::KIND_WRITE: if (ph == E_IDLE)
				start_cmd(k == sdspi_pkg::KIND_READ ? sdspi_pkg::CMD17 : sdspi_pkg::CMD24,
					ctype == 2'd3 ? lba : {lba[22:0], 9'd0}, 8'hFF);
			sdspi_pkg::KIND_XFER: if (ph != E_IDLE && ph != E_TICK) on_exchange(rx, wr);
			sdspi_pkg::KIND_TICK: if (ph == E_TICK) start_cmd(sdspi_pkg::CMD55, '0, 8'h65);
			default: ;
		endcase
		w.fast = fast;
		w.wtick = (ph == E_TICK);
		w.ctype = ctype;
		return w;
	endfunction

	// ---- stimulus ----
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	// valid drops only when a real gap follows
	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 30))
			: int'($urandom_range(0, 2));
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// sends one word and records its prediction
	task automatic send_word(logic [2:0] k, logic [31:0] lba = '0,
			logic [7:0] rx = 8'hFF, logic [7:0] wr = 8'h00);
		idle_gap();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, wr, rx, lba, k};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_words.push_back(predict_card_word(k, lba, rx, wr));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == sdspi_pkg::REG_ACMD41) att_lim = val[7:0];
		else poll_lim = val;
	endtask

	// answers one exchange with a byte fitting the current phase
	function automatic logic [7:0] card_reply(bit good);
		if (!good) return 8'($urandom_range(0, 255));
		case (ph)
			E_WAITRDY: return 8'hFF;
			E_RESP: case (fcmd())
				sdspi_pkg::CMD0, sdspi_pkg::CMD8, sdspi_pkg::CMD55: return 8'h01;
				default: return 8'h00;
			endcase
			E_R7: return nbytes == 16'd2 ? 8'h01 : 8'hAA;
			E_OCR: return $urandom_range(0, 1) ? 8'hC0 : 8'h80;
			E_TOKEN: return 8'hFE;
			E_WRESP: return 8'hE5;
			E_WBUSY: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// runs an operation to idle; bad_pct percent of the replies are random bytes
	task automatic run_op(logic [2:0] k, int bad_pct);
		int n;
		send_word(k, $urandom(), 8'h00, 8'h00);
		n = 0;
		while (ph != E_IDLE && n < 2000) begin
			if (ph == E_TICK) send_word(sdspi_pkg::KIND_TICK);
			else send_word(sdspi_pkg::KIND_XFER, $urandom(),
				card_reply($urandom_range(0, 99) >= bad_pct), 8'($urandom_range(0, 255)));
			n++;
		end
	endtask

	task automatic test_directed();
		// stray events while idle, unknown kinds
		send_word(sdspi_pkg::KIND_XFER, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		send_word(sdspi_pkg::KIND_TICK);
		send_word(3'd5); send_word(3'd6); send_word(3'd7, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		// read before init, byte addressing on unknown card, max address, starts while busy
		send_word(sdspi_pkg::KIND_READ, 32'hFFFF_FFFF);
		send_word(sdspi_pkg::KIND_INIT);
		send_word(sdspi_pkg::KIND_WRITE, 32'h0);
		// response timeout: all 0xFF replies
		repeat (15) send_word(sdspi_pkg::KIND_XFER, 32'h0, 8'hFF, 8'h00);
	endtask

	task automatic test_init_variants();
		// finish the read left running, clean replies
		write_reg(sdspi_pkg::REG_POLL, 16'd1);
		run_op(sdspi_pkg::KIND_INIT, 0);
		// one ACMD41 try, short ready poll, noisy replies
		write_reg(sdspi_pkg::REG_ACMD41, 16'd1);
		write_reg(sdspi_pkg::REG_POLL, 16'd3);
		run_op(sdspi_pkg::KIND_INIT, 25);
	endtask

	task automatic test_block_io();
		run_op(sdspi_pkg::KIND_READ, 0);
		drain();                 // sender waits for every result
		stall_rx = 1'b1;
		run_op(sdspi_pkg::KIND_WRITE, 100);
		stall_rx = 1'b0;
	endtask

	task automatic test_random();
		int i;
		write_reg(sdspi_pkg::REG_POLL, 16'hFFFF);
		for (i = 0; i < 12; i++)
			send_word(3'($urandom_range(0, 7)), $urandom(),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// ---- result checking ----
	always @(posedge clk) begin
		card_word_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0)
				report_mismatch("unexpected word", m_axis_tdata, 32'd0);
			else begin
				e = expected_words.pop_front();
				if (m_axis_tdata[0] !== e.send)
					report_mismatch("send_valid", 32'(m_axis_tdata[0]), 32'(e.send));
				if (m_axis_tdata[8:1] !== e.tx)
					report_mismatch("tx_byte", 32'(m_axis_tdata[8:1]), 32'(e.tx));
				if (m_axis_tdata[9] !== e.cs)
					report_mismatch("chip_select", 32'(m_axis_tdata[9]), 32'(e.cs));
				if (m_axis_tdata[10] !== e.fast)
					report_mismatch("fast_clock", 32'(m_axis_tdata[10]), 32'(e.fast));
				if (m_axis_tdata[11] !== e.wtick)
					report_mismatch("wait_tick", 32'(m_axis_tdata[11]), 32'(e.wtick));
				if (m_axis_tdata[12] !== e.rdv)
					report_mismatch("rd_valid", 32'(m_axis_tdata[12]), 32'(e.rdv));
				if (m_axis_tdata[20:13] !== e.rdb)
					report_mismatch("rd_byte", 32'(m_axis_tdata[20:13]), 32'(e.rdb));
				if (m_axis_tlast !== e.rdl)
					report_mismatch("rd_last", 32'(m_axis_tlast), 32'(e.rdl));
				if (m_axis_tdata[21] !== e.wrt)
					report_mismatch("wr_taken", 32'(m_axis_tdata[21]), 32'(e.wrt));
				if (m_axis_tdata[22] !== e.done)
					report_mismatch("done_res", 32'(m_axis_tdata[22]), 32'(e.done));
				if (m_axis_tdata[24:23] !== e.st)
					report_mismatch("status", 32'(m_axis_tdata[24:23]), 32'(e.st));
				if (m_axis_tdata[26:25] !== e.ctype)
					report_mismatch("card_type", 32'(m_axis_tdata[26:25]), 32'(e.ctype));
			end
		end
	end

	// receiver stalls: mostly short, a few long, some clean stretches
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_rx) m_axis_tready <= (r < 10);
		else if ((cycles / 2000) % 3 == 0) m_axis_tready <= 1'b1;
		else m_axis_tready <= (r >= 25);
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		ph = E_IDLE; nbytes = '0; npoll = '0; natt = '0; att_lim = 8'd200;
		poll_lim = 16'hFFFF; ctype = '0; frame = '0; reply = '0; v2 = 1'b0; fast = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_init_variants();
		test_block_io();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
